/* src/bhpq_pkg.sv */
// Package for the binary heap priority queue core: sizes, codes, controller state type.
// Depends on nothing; used by every module under src except bhpq_ram.
`timescale 1ns / 1ps
package bhpq_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int KEY_BITS_DEF = 32;
  localparam int TAG_BITS_DEF = 16;

  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int POS_W = 9;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_PEEK   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE_RD,
    S_PRE_WT,
    S_LAST_WT,
    S_RD_A,
    S_WT_A,
    S_RD_B,
    S_WT_B,
    S_DECIDE,
    S_WR_A,
    S_WR_B,
    S_ROOT_RD,
    S_ROOT_WT,
    S_DONE
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture input beat
    logic rd_pre;    // read root for delete, target slot for update
    logic cap_pre;   // capture removed root or kept tag
    logic rd_last;   // read the last entry for delete
    logic cap_last;  // capture last entry as the moving entry
    logic rd_a;      // read slot at address a
    logic rd_b;      // read slot at address b
    logic cap_a;     // capture read data into reg a
    logic cap_b;     // capture read data into reg b
    logic wr_a;      // write entry a
    logic wr_b;      // write entry b
    logic step;      // move cursor after a swap
    logic wr_fin;    // write the moving entry at its resting slot
    logic rd_root;   // read the root
    logic cap_root;  // capture root
    logic finish;    // build result beat
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic bad;       // request fails, no heap work
    logic op_swim;   // sift up, else sift down
    logic op_del;    // delete request
    logic skip;      // no heap movement needed
    logic no_parent; // cursor at root
    logic no_child;  // cursor has no child
    logic one_child; // only left child exists
    logic do_swap;   // compare says move
  } dp_stat_t;

endpackage

/* src/bhpq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bhpq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/bhpq_ctrl.sv */
// Controller state machine for the heap core: sequences reads, compares, swaps.
// Depends on bhpq_pkg.
`timescale 1ns / 1ps
module bhpq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_busy,
  input  bhpq_pkg::dp_stat_t stat,
  output bhpq_pkg::dp_cmd_t  cmd,
  output logic               idle
);
  import bhpq_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    idle = 1'b0;
    case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_PRE_RD;
        end
      end
      // delete and update fetch their starting entry first
      S_PRE_RD: begin
        if (stat.bad || stat.skip || stat.op_swim) begin
          state_nxt = S_RD_A;
        end else begin
          cmd.rd_pre = 1'b1;
          state_nxt = S_PRE_WT;
        end
      end
      S_PRE_WT: begin
        cmd.cap_pre = 1'b1;
        if (stat.op_del) begin
          cmd.rd_last = 1'b1;
          state_nxt = S_LAST_WT;
        end else begin
          state_nxt = S_RD_A;
        end
      end
      S_LAST_WT: begin
        cmd.cap_last = 1'b1;
        state_nxt = S_RD_A;
      end
      S_RD_A: begin
        if (stat.bad || stat.skip) begin
          state_nxt = S_ROOT_RD;
        end else if (stat.op_swim && stat.no_parent) begin
          state_nxt = S_ROOT_RD;
        end else if (!stat.op_swim && stat.no_child) begin
          state_nxt = S_ROOT_RD;
        end else begin
          cmd.rd_a = 1'b1;
          state_nxt = S_WT_A;
        end
      end
      S_WT_A: begin
        cmd.cap_a = 1'b1;
        if (!stat.op_swim && !stat.one_child) begin
          cmd.rd_b = 1'b1;
          state_nxt = S_WT_B;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_WT_B: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.do_swap) begin
          state_nxt = S_WR_A;
        end else begin
          state_nxt = S_ROOT_RD;
        end
      end
      S_WR_A: begin
        cmd.wr_a = 1'b1;
        state_nxt = S_WR_B;
      end
      S_WR_B: begin
        cmd.wr_b = 1'b1;
        cmd.step = 1'b1;
        state_nxt = S_RD_A;
      end
      S_ROOT_RD: begin
        cmd.wr_fin = !stat.bad && !stat.skip;
        cmd.rd_root = 1'b1;
        state_nxt = S_ROOT_WT;
      end
      S_ROOT_WT: begin
        cmd.cap_root = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // swaps only happen on real heap work and their writes come in pairs; load leaves idle, finish returns to it
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_a |=> cmd.wr_b) else $error("swap write not paired");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !idle) else $error("controller idle after load");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> idle) else $error("finish without return to idle");
endmodule

/* src/bhpq_dp.sv */
// Datapath for the heap core: heap RAM, entry count, cursor, compare and result.
// Depends on bhpq_pkg and bhpq_ram.
`timescale 1ns / 1ps
module bhpq_dp #(
  parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = bhpq_pkg::KEY_BITS_DEF,
  parameter int TAG_BITS = bhpq_pkg::TAG_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       largest_first,
  input  logic [1:0]                 in_opcode,
  input  logic [bhpq_pkg::KEY_W-1:0] in_key,
  input  logic [bhpq_pkg::TAG_W-1:0] in_tag,
  input  logic [bhpq_pkg::POS_W-1:0] in_pos,
  input  bhpq_pkg::dp_cmd_t          cmd,
  output bhpq_pkg::dp_stat_t         stat,
  output logic                       res_load,
  output logic [1:0]                 res_status,
  output logic                       res_top_valid,
  output logic [bhpq_pkg::KEY_W-1:0] res_top_key,
  output logic [bhpq_pkg::TAG_W-1:0] res_top_tag,
  output logic [bhpq_pkg::POS_W-1:0] res_total,
  output logic [bhpq_pkg::POS_W-1:0] res_final
);
  import bhpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);  // count / position width
  localparam int AW = $clog2(CAPACITY);      // ram address width
  localparam int EW = KEY_BITS + TAG_BITS;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cur_r;
  logic [1:0]    op_r;
  logic          bad_r, skip_r;
  logic [1:0]    stat_r;
  logic [EW-1:0] ent_r;       // the entry in motion
  logic [EW-1:0] a_r, b_r;    // neighbor entries read
  logic [CW-1:0] nb_r;        // chosen neighbor position
  logic [EW-1:0] root_r;
  logic [EW-1:0] del_r;       // removed root on delete
  logic [KEY_BITS-1:0] key_in;
  logic [TAG_BITS-1:0] tag_in;
  logic [CW-1:0] pos_in;
  logic          root_fwd;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [CW-1:0] rpos;

  assign key_in = KEY_BITS'(in_key);
  assign tag_in = TAG_BITS'(in_tag);
  assign pos_in = (in_pos > POS_W'(CAPACITY)) ? CW'(CAPACITY + 1) : CW'(in_pos);

  function automatic logic above(input logic lf, input logic [KEY_BITS-1:0] x,
                                 input logic [KEY_BITS-1:0] y);
    above = lf ? (x > y) : (x < y);
  endfunction

  // heap store, position p lives at address p-1
  bhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // read address selection
  always_comb begin
    rpos = CW'(1);
    if (cmd.rd_pre) begin
      rpos = cur_r;
    end else if (cmd.rd_last) begin
      rpos = count_r + CW'(1);
    end else if (cmd.rd_a) begin
      rpos = (op_r == OP_INSERT) ? (cur_r >> 1) : CW'({cur_r, 1'b0});
    end else if (cmd.rd_b) begin
      rpos = CW'({cur_r, 1'b1});
    end
    raddr = AW'(rpos - CW'(1));
  end

  logic [CW:0] two_p;
  assign two_p = {cur_r, 1'b0};

  // status toward the controller
  always_comb begin
    stat.bad       = bad_r;
    stat.op_swim   = (op_r == OP_INSERT);
    stat.op_del    = (op_r == OP_DELETE);
    stat.skip      = skip_r;
    stat.no_parent = (cur_r <= CW'(1));
    stat.no_child  = (two_p > {1'b0, count_r});
    stat.one_child = (two_p == {1'b0, count_r});
    if (op_r == OP_INSERT) begin
      stat.do_swap = above(largest_first, ent_r[EW-1 -: KEY_BITS], a_r[EW-1 -: KEY_BITS]);
    end else if (stat.one_child || !above(largest_first, b_r[EW-1 -: KEY_BITS],
                                          a_r[EW-1 -: KEY_BITS])) begin
      stat.do_swap = above(largest_first, a_r[EW-1 -: KEY_BITS], ent_r[EW-1 -: KEY_BITS]);
    end else begin
      stat.do_swap = above(largest_first, b_r[EW-1 -: KEY_BITS], ent_r[EW-1 -: KEY_BITS]);
    end
  end

  // write port: swaps write both slots, the walk ends by writing the moving entry
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = ent_r;
    if (cmd.wr_a) begin
      we = 1'b1;
      waddr = AW'(cur_r - CW'(1));
      wdata = (op_r == OP_INSERT) ? a_r : ((nb_r[0]) ? b_r : a_r);
    end else if (cmd.wr_b) begin
      we = 1'b1;
      waddr = AW'(nb_r - CW'(1));
      wdata = ent_r;
    end else if (cmd.wr_fin) begin
      we = 1'b1;
      waddr = AW'(cur_r - CW'(1));
      wdata = ent_r;
    end
  end

  // root read coincides with the final write, forward when it lands on the root
  assign root_fwd = !bad_r && !skip_r && (cur_r == CW'(1));

  // neighbor position after compare
  logic [CW-1:0] nb_sel;
  always_comb begin
    if (op_r == OP_INSERT) begin
      nb_sel = cur_r >> 1;
    end else if (stat.one_child || !above(largest_first, b_r[EW-1 -: KEY_BITS],
                                          a_r[EW-1 -: KEY_BITS])) begin
      nb_sel = CW'(two_p);
    end else begin
      nb_sel = CW'(two_p) + CW'(1);
    end
  end

  // count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.load) begin
      case (opcode_t'(in_opcode))
        OP_INSERT: if (count_r < CW'(CAPACITY)) count_nxt = count_r + CW'(1);
        OP_DELETE: if (count_r != '0) count_nxt = count_r - CW'(1);
        default:   count_nxt = count_r;
      endcase
    end
  end

  // payload registers; delete and update preload their entry from the store
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      stat_r <= ST_OK;
      bad_r <= 1'b0;
      skip_r <= 1'b0;
      case (opcode_t'(in_opcode))
        OP_INSERT: begin
          ent_r <= {key_in, tag_in};
          cur_r <= count_r + CW'(1);
          if (count_r >= CW'(CAPACITY)) begin
            bad_r <= 1'b1;
            stat_r <= ST_FULL;
          end
        end
        OP_DELETE: begin
          cur_r <= CW'(1);
          if (count_r == '0) begin
            bad_r <= 1'b1;
            stat_r <= ST_EMPTY;
          end
        end
        OP_UPDATE: begin
          cur_r <= pos_in;
          ent_r[EW-1 -: KEY_BITS] <= key_in;
          if (pos_in == '0 || pos_in > count_r) begin
            bad_r <= 1'b1;
            stat_r <= ST_RANGE;
          end
        end
        default: begin
          skip_r <= 1'b1;
          if (count_r == '0) stat_r <= ST_EMPTY;
        end
      endcase
    end
    if (cmd.cap_pre) begin
      if (op_r == OP_DELETE) begin
        del_r <= rdata;
      end else begin
        ent_r[TAG_BITS-1:0] <= rdata[TAG_BITS-1:0];
      end
    end
    if (cmd.cap_last) ent_r <= rdata;
    if (cmd.cap_a) a_r <= rdata;
    if (cmd.cap_b) b_r <= rdata;
    if (cmd.step) cur_r <= nb_r;
    if (cmd.cap_root) root_r <= root_fwd ? ent_r : rdata;
    nb_r <= nb_sel;
  end

  // result beat
  logic [CW-1:0] fin;
  always_comb begin
    res_load = cmd.finish;
    res_status = stat_r;
    res_total = POS_W'(count_r);
    res_top_valid = (count_r != '0);
    fin = (bad_r || op_r == OP_DELETE || op_r == OP_PEEK) ? '0 : cur_r;
    res_final = POS_W'(fin);
    if (op_r == OP_DELETE && !bad_r) begin
      res_top_key = KEY_W'(del_r[EW-1 -: KEY_BITS]);
      res_top_tag = TAG_W'(del_r[TAG_BITS-1:0]);
    end else if (count_r != '0) begin
      res_top_key = KEY_W'(root_r[EW-1 -: KEY_BITS]);
      res_top_tag = TAG_W'(root_r[TAG_BITS-1:0]);
    end else begin
      res_top_key = '0;
      res_top_tag = '0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("entry count above capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_b |-> nb_r != '0) else $error("swap into position zero");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && op_r == OP_INSERT |-> nb_r < cur_r) else $error("swim moved down");
endmodule

/* src/binary_heap_priority_queue_core.sv */
// Binary min/max heap priority queue core (controller plus datapath).
// Sequence: peek and failed requests go straight to the root read and the result; delete first
// reads the root and the last entry, update the target slot; each swim level reads the parent,
// each sink level one or both children, then compares and swaps until a compare stops the walk.
// Throughput: one item at a time; the next beat is taken the cycle after the result is
// registered, a stalled result holds the controller. One RAM read port sets the rate.
// Reset (rst_n, synchronous) empties the heap and selects smallest-first; no RAM clearing.
`timescale 1ns / 1ps
module binary_heap_priority_queue_core #(
  parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = bhpq_pkg::KEY_BITS_DEF,
  parameter int TAG_BITS = bhpq_pkg::TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // opcode[1:0], new_key[33:2], new_tag[49:34], position[58:50]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // status[1:0], top_valid[2], top_key[34:3], top_tag[50:35],
                                  // entry_total[59:51], final_position[68:60]
);
  import bhpq_pkg::*;

  logic lf_r;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic idle;
  logic res_load, tv;
  logic [1:0] st;
  logic [KEY_W-1:0] tk;
  logic [TAG_W-1:0] tt;
  logic [POS_W-1:0] tot, fp;
  logic out_valid_r;
  logic [71:0] out_data_r;

  // ordering mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lf_r <= 1'b0;
    end else if (cfg_we) begin
      lf_r <= cfg_wdata;
    end
  end

  assign in_tready = idle;

  bhpq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && idle),
    .out_busy(out_valid_r && !out_tready), .stat(stat), .cmd(cmd), .idle(idle)
  );

  bhpq_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .largest_first(lf_r),
    .in_opcode(in_tdata[1:0]), .in_key(in_tdata[33:2]), .in_tag(in_tdata[49:34]),
    .in_pos(in_tdata[58:50]), .cmd(cmd), .stat(stat), .res_load(res_load),
    .res_status(st), .res_top_valid(tv), .res_top_key(tk), .res_top_tag(tt),
    .res_total(tot), .res_final(fp)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_load) begin
      out_data_r <= {3'b0, fp, tot, tt, tk, tv, st};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
endmodule
